// ===== hdl/cmdf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cross median denoise filter: shared definitions
// Register codes, configuration widths and the control structures that pass
// between the window and median stages.
// ----------------------------------------------------------------------------
package cmdf_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int LEN_W      = 11;
    localparam int CNT_W      = 12;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
    localparam logic [CNT_W-1:0] CNT_RESET = 12'd1024;
    localparam logic [CNT_W-1:0] CNT_MIN   = 12'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_LENGTH = 1'b0,
        CFG_LINE_COUNT  = 1'b1
    } t_cfg_reg;

    // Where the pixel being filtered lies within the frame.
    typedef struct packed {
        logic fast_first;
        logic fast_last;
        logic slow_first;
        logic slow_last;
    } t_edge;

    // Control that travels with a result through the median stages.
    typedef struct packed {
        logic valid;
        logic last;
    } t_res_ctl;

endpackage
`default_nettype wire

// ===== hdl/cmdf_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cross median denoise filter: channel interfaces
// Pixel input stream, filtered result stream and register write channel.
// ----------------------------------------------------------------------------
interface cmdf_pix_if #(
    parameter int PIXEL_BITS = 8
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface cmdf_res_if #(
    parameter int PIXEL_BITS = 8
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface cmdf_cfg_if ();
    import cmdf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/cmdf_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cross median denoise filter: line memory and window
// Tracks frame position, keeps four lines of history in one memory of
// packed columns, and selects the five median operands for each pixel.
// ----------------------------------------------------------------------------
module cmdf_window #(
    parameter int MAX_LINE   = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int MLEN_W     = 11
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_adv,
    input  wire logic                                 i_acc,
    input  wire logic [PIXEL_BITS-1:0]                i_pixel,
    input  wire logic [MLEN_W-1:0]                    i_line_len,
    input  wire logic [cmdf_pkg::CNT_W-1:0]           i_line_cnt,
    output cmdf_pkg::t_res_ctl                        o_ctl,
    output logic      [4:0][PIXEL_BITS-1:0]           o_opnd
);
    import cmdf_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_LINE);
    localparam int FAST_W  = $clog2(MAX_LINE);
    localparam int PRIME_W = MLEN_W + 1;
    localparam int WORD_W  = 4 * PIXEL_BITS;

    // Position and priming state.
    logic [ADDR_W-1:0]  r_addr;
    logic [PRIME_W-1:0] r_prime;
    logic [FAST_W-1:0]  r_fast;
    logic [CNT_W-1:0]   r_slow;

    logic   emit;
    logic   last;
    logic   wrap;
    t_edge  edge_pos;

    assign emit                = r_prime >= {i_line_len, 1'b0};
    assign edge_pos.fast_first = (r_fast == '0);
    assign edge_pos.fast_last  = MLEN_W'(r_fast) >= (i_line_len - MLEN_W'(1));
    assign edge_pos.slow_first = (r_slow == '0);
    assign edge_pos.slow_last  = r_slow >= (i_line_cnt - CNT_W'(1));
    assign last                = emit && edge_pos.fast_last && edge_pos.slow_last;
    // The memory delays by line_length-2 columns; the tap registers add the
    // last two.
    assign wrap                = MLEN_W'(r_addr) >= (i_line_len - MLEN_W'(3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_prime <= '0;
            r_fast  <= '0;
            r_slow  <= '0;
        end else if (i_acc) begin
            // Each frame starts the column addresses from zero, so the delay
            // follows the line length that is set for that frame.
            r_addr <= (wrap || last) ? '0 : r_addr + 1'b1;
            if (last) begin
                r_prime <= '0;
                r_fast  <= '0;
                r_slow  <= '0;
            end else if (!emit) begin
                r_prime <= r_prime + 1'b1;
            end else if (edge_pos.fast_last) begin
                r_fast <= '0;
                r_slow <= r_slow + 1'b1;
            end else begin
                r_fast <= r_fast + 1'b1;
            end
        end
    end

    // First stage: the item whose memory word is being read.
    logic                  r1_valid;
    logic [PIXEL_BITS-1:0] r1_pix;
    logic [ADDR_W-1:0]     r1_addr;
    logic                  r1_emit;
    logic                  r1_last;
    t_edge                 r1_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r1_pix  <= i_pixel;
            r1_addr <= r_addr;
            r1_emit <= emit;
            r1_last <= last;
            r1_edge <= edge_pos;
        end
    end

    // Column memory: each word holds the pixel and the three above it.
    logic [WORD_W-1:0] line_mem [MAX_LINE];
    logic [WORD_W-1:0] r_rd_data;
    logic [WORD_W-1:0] r_fwd_data;
    logic              r_fwd;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rd_word;

    assign wr_en = r1_valid && i_adv;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            line_mem[r1_addr] <= wr_data;
        end
        if (i_acc) begin
            r_rd_data <= line_mem[r_addr];
        end
    end

    // A read that meets the write of the previous item at the same address
    // takes the written word instead of the stale one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_acc) begin
            r_fwd <= wr_en && (r1_addr == r_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_fwd_data <= wr_data;
        end
    end

    assign rd_word = r_fwd ? r_fwd_data : r_rd_data;

    // Tap registers, one per line of history, two columns deep; the center
    // line is four deep for the left neighbors.
    logic [PIXEL_BITS-1:0] r_tap1 [2];
    logic [PIXEL_BITS-1:0] r_tap2 [4];
    logic [PIXEL_BITS-1:0] r_tap3 [2];
    logic [PIXEL_BITS-1:0] r_tap4 [2];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tap1[0] <= rd_word[0*PIXEL_BITS +: PIXEL_BITS];
            r_tap1[1] <= r_tap1[0];
            r_tap2[0] <= rd_word[1*PIXEL_BITS +: PIXEL_BITS];
            r_tap2[1] <= r_tap2[0];
            r_tap2[2] <= r_tap2[1];
            r_tap2[3] <= r_tap2[2];
            r_tap3[0] <= rd_word[2*PIXEL_BITS +: PIXEL_BITS];
            r_tap3[1] <= r_tap3[0];
            r_tap4[0] <= rd_word[3*PIXEL_BITS +: PIXEL_BITS];
            r_tap4[1] <= r_tap4[0];
        end
    end

    assign wr_data = {r_tap3[1], r_tap2[1], r_tap1[1], r1_pix};

    logic [PIXEL_BITS-1:0] p_c, p_l1, p_l2, p_r1, p_r2, p_u1, p_u2, p_d1, p_d2;

    assign p_c  = r_tap2[1];
    assign p_r1 = r_tap2[0];
    assign p_r2 = rd_word[1*PIXEL_BITS +: PIXEL_BITS];
    assign p_l1 = r_tap2[2];
    assign p_l2 = r_tap2[3];
    assign p_u1 = r_tap3[1];
    assign p_u2 = r_tap4[1];
    assign p_d1 = r_tap1[1];
    assign p_d2 = r1_pix;

    // Corners pad the three samples with a floor and a ceiling so that one
    // five-input median serves every case.
    logic [4:0][PIXEL_BITS-1:0] opnd;
    logic                       on_fast_edge;
    logic                       on_slow_edge;

    assign on_fast_edge = r1_edge.fast_first || r1_edge.fast_last;
    assign on_slow_edge = r1_edge.slow_first || r1_edge.slow_last;

    always_comb begin
        opnd[0] = p_c;
        if (on_fast_edge && on_slow_edge) begin
            opnd[1] = r1_edge.fast_first ? p_r1 : p_l1;
            opnd[2] = r1_edge.slow_first ? p_d1 : p_u1;
            opnd[3] = '0;
            opnd[4] = '1;
        end else if (on_slow_edge) begin
            opnd[1] = p_l1;
            opnd[2] = p_r1;
            opnd[3] = r1_edge.slow_first ? p_d1 : p_u1;
            opnd[4] = r1_edge.slow_first ? p_d2 : p_u2;
        end else if (on_fast_edge) begin
            opnd[1] = p_u1;
            opnd[2] = p_d1;
            opnd[3] = r1_edge.fast_first ? p_r1 : p_l1;
            opnd[4] = r1_edge.fast_first ? p_r2 : p_l2;
        end else begin
            opnd[1] = p_l1;
            opnd[2] = p_r1;
            opnd[3] = p_u1;
            opnd[4] = p_d1;
        end
    end

    t_res_ctl r2_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (i_adv) begin
            r2_ctl.valid <= r1_valid && r1_emit;
            r2_ctl.last  <= r1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_opnd <= opnd;
        end
    end

    assign o_ctl = r2_ctl;

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && last |=> r_fast == '0 && r_slow == '0 && r_prime == '0)
        else $error("position did not restart after the last pixel of a frame");

    a_priming_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && !emit |=> $stable(r_fast) && $stable(r_slow))
        else $error("position moved during priming");

    a_fast_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && emit && !edge_pos.fast_last |=> r_fast == FAST_W'($past(r_fast) + 1'b1))
        else $error("fast position did not step by one");

endmodule
`default_nettype wire

// ===== hdl/cmdf_median.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cross median denoise filter: median of five
// Two registered compare stages reduce five operands to three; the median
// of those three is formed for the output register.
// ----------------------------------------------------------------------------
module cmdf_median #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_adv,
    input  wire cmdf_pkg::t_res_ctl                   i_ctl,
    input  wire logic [4:0][PIXEL_BITS-1:0]           i_opnd,
    output cmdf_pkg::t_res_ctl                        o_ctl,
    output logic      [PIXEL_BITS-1:0]                o_median
);
    import cmdf_pkg::*;

    t_res_ctl              r3_ctl;
    t_res_ctl              r4_ctl;
    logic [PIXEL_BITS-1:0] r3_lo_a, r3_hi_a, r3_lo_b, r3_hi_b, r3_e;
    logic [PIXEL_BITS-1:0] r4_mid_a, r4_mid_b, r4_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else if (i_adv) begin
            r3_ctl <= i_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    // Of four samples, the larger of the pair minima and the smaller of the
    // pair maxima are the two middle ones; the fifth decides between them.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_lo_a  <= (i_opnd[0] < i_opnd[1]) ? i_opnd[0] : i_opnd[1];
            r3_hi_a  <= (i_opnd[0] < i_opnd[1]) ? i_opnd[1] : i_opnd[0];
            r3_lo_b  <= (i_opnd[2] < i_opnd[3]) ? i_opnd[2] : i_opnd[3];
            r3_hi_b  <= (i_opnd[2] < i_opnd[3]) ? i_opnd[3] : i_opnd[2];
            r3_e     <= i_opnd[4];
            r4_mid_a <= (r3_lo_a > r3_lo_b) ? r3_lo_a : r3_lo_b;
            r4_mid_b <= (r3_hi_a < r3_hi_b) ? r3_hi_a : r3_hi_b;
            r4_e     <= r3_e;
        end
    end

    logic [PIXEL_BITS-1:0] mid_lo, mid_hi, hi_cap;

    assign mid_lo   = (r4_mid_a < r4_mid_b) ? r4_mid_a : r4_mid_b;
    assign mid_hi   = (r4_mid_a < r4_mid_b) ? r4_mid_b : r4_mid_a;
    assign hi_cap   = (mid_hi < r4_e) ? mid_hi : r4_e;
    assign o_median = (mid_lo > hi_cap) ? mid_lo : hi_cap;
    assign o_ctl    = r4_ctl;

endmodule
`default_nettype wire

// ===== hdl/cross_median_denoise_filter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cross median denoise filter: top level
// Five-point cross median over a streamed gray-scale frame.
// ----------------------------------------------------------------------------
// The filter takes one pixel per clock in memory order while i_pix.ready is
// high and gives one filtered pixel for every item from item 2*line_length of
// the frame on, so the host follows each frame with 2*line_length drain items
// whose values are unused. The result for pixel p comes from item
// p + 2*line_length. The rate is set by the column memory: MAX_LINE words of
// 4*PIXEL_BITS bits, one read and one write per item, with the word written
// by one item forwarded to the next item's read. The memory needs no clearing
// after reset. An input transfer is taken whenever the output register is
// empty, is being emptied, or the median pipeline holds no result at its end.
// The register port is always ready; the user must write line_length and
// line_count only while no frame is in progress, which is not enforced.
// ----------------------------------------------------------------------------
module cross_median_denoise_filter_top #(
    parameter int MAX_LINE   = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cmdf_cfg_if.sink    i_cfg,
    cmdf_pix_if.sink    i_pix,
    cmdf_res_if.source  o_res
);
    import cmdf_pkg::*;

    localparam int MLEN_W = $clog2(MAX_LINE + 1);
    localparam int EXT_W  = (LEN_W > MLEN_W) ? LEN_W : MLEN_W;

    logic [LEN_W-1:0] r_line_length;
    logic [CNT_W-1:0] r_line_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LEN_RESET;
            r_line_count  <= CNT_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_LINE_LENGTH: r_line_length <= i_cfg.data[LEN_W-1:0];
                CFG_LINE_COUNT:  r_line_count  <= i_cfg.data;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // Sizes out of range are saturated to what the frame logic supports.
    logic [EXT_W-1:0]  len_ext;
    logic [MLEN_W-1:0] line_len_eff;
    logic [CNT_W-1:0]  line_cnt_eff;

    assign len_ext = EXT_W'(r_line_length);

    always_comb begin
        if (len_ext < EXT_W'(3)) begin
            line_len_eff = MLEN_W'(3);
        end else if (len_ext > EXT_W'(MAX_LINE)) begin
            line_len_eff = MLEN_W'(MAX_LINE);
        end else begin
            line_len_eff = MLEN_W'(len_ext);
        end
    end

    assign line_cnt_eff = (r_line_count < CNT_MIN) ? CNT_MIN : r_line_count;

    // Pipeline control.
    t_res_ctl              med_ctl;
    logic [PIXEL_BITS-1:0] med_value;
    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_pixel_out;
    logic                  r_frame_last;
    logic                  out_free;
    logic                  adv;
    logic                  acc;

    assign out_free    = !r_out_valid || o_res.ready;
    assign adv         = out_free || !med_ctl.valid;
    assign acc         = i_pix.valid && adv;
    assign i_pix.ready = adv;

    t_res_ctl                   win_ctl;
    logic [4:0][PIXEL_BITS-1:0] win_opnd;

    cmdf_window #(
        .MAX_LINE   (MAX_LINE),
        .PIXEL_BITS (PIXEL_BITS),
        .MLEN_W     (MLEN_W)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_acc      (acc),
        .i_pixel    (i_pix.pixel_in),
        .i_line_len (line_len_eff),
        .i_line_cnt (line_cnt_eff),
        .o_ctl      (win_ctl),
        .o_opnd     (win_opnd)
    );

    cmdf_median #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_ctl    (win_ctl),
        .i_opnd   (win_opnd),
        .o_ctl    (med_ctl),
        .o_median (med_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= med_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && med_ctl.valid) begin
            r_pixel_out  <= med_value;
            r_frame_last <= med_ctl.last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.pixel_out  = r_pixel_out;
    assign o_res.frame_last = r_frame_last;

endmodule
`default_nettype wire
